@@ rtl/ccba_pkg.sv @@
// Shared types, constants and helpers for the cascaded circular bearing averager.
// No dependencies; every other file refers to it by scoped names.
package ccba_pkg;

    localparam int NWIN     = 5;
    localparam int MAXLEN   = 32;
    localparam int WIN_W    = 3;
    localparam int POS_W    = 5;
    localparam int LEN_W    = 6;
    localparam int Q_W      = 16;
    localparam int BRG_W    = 16;
    localparam int SUM_W    = 21;
    localparam int CXY_W    = 21;
    localparam int CZ_W     = 25;
    localparam int TICK_W   = 11;
    localparam int IT_W     = 4;
    localparam int DCNT_W   = 5;
    localparam int DVD_W    = 20;

    localparam int LEN_FAST_DEF      = 5;
    localparam int LEN_SECOND_DEF    = 10;
    localparam int LEN_THREE_SEC_DEF = 30;
    localparam int LEN_HALF_MIN_DEF  = 30;
    localparam int LEN_TEN_MIN_DEF   = 20;

    localparam logic signed [Q_W-1:0] QONE = 16'sd32767;
    localparam logic [16:0] FULL_TURN  = 17'd36000;
    localparam logic [16:0] QUARTER    = 17'd9000;
    localparam logic [16:0] HALF_TURN  = 17'd18000;
    localparam logic [16:0] THREE_QTR  = 17'd27000;
    localparam int          ANG_SHIFT  = 8;
    localparam logic [IT_W-1:0] CORDIC_LAST = 4'd15;
    localparam logic signed [CXY_W-1:0] CORDIC_X0 = 21'sd79595;
    localparam logic signed [CZ_W-1:0]  Z_HALF_TURN = 25'sd4608000;
    localparam logic [DCNT_W-1:0] DIV_LAST = 5'd19;

    localparam logic [2:0]        PHASE_LAST  = 3'd4;
    localparam logic [5:0]        SLOW_LAST   = 6'd49;
    localparam logic [TICK_W-1:0] TEN_MIN_TICK    = 11'd1504;
    localparam logic [TICK_W-1:0] TEN_MIN_RESTART = 11'd4;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_PRESET = 1'b1;

    typedef struct packed {
        logic                   rd;
        logic                   wr;
        logic                   clr;
        logic [WIN_W-1:0]       win;
        logic [POS_W-1:0]       pos;
        logic signed [Q_W-1:0]  vc;
        logic signed [Q_W-1:0]  vs;
    } t_ring_req;

    typedef struct packed {
        logic                   start;
        logic                   vec;
        logic [BRG_W-1:0]       bearing;
        logic signed [Q_W-1:0]  vx;
        logic signed [Q_W-1:0]  vy;
    } t_cordic_req;

    typedef struct packed {
        logic                   done;
        logic signed [Q_W-1:0]  c;
        logic signed [Q_W-1:0]  s;
        logic [BRG_W-1:0]       bearing;
    } t_cordic_rsp;

    function automatic logic [LEN_W-1:0] clamp_len(input int l);
        if (l < 1) return LEN_W'(1);
        if (l > MAXLEN) return LEN_W'(MAXLEN);
        return LEN_W'(l);
    endfunction

    function automatic logic signed [Q_W-1:0] sat_q15(input logic signed [CXY_W-1:0] v);
        if (v > CXY_W'(QONE)) return QONE;
        if (v < -CXY_W'(QONE)) return -QONE;
        return v[Q_W-1:0];
    endfunction

    // arctan(2^-i) in 1/25600 degree
    function automatic logic signed [CZ_W-1:0] atan_step(input logic [IT_W-1:0] i);
        logic signed [CZ_W-1:0] a;
        unique case (i)
            4'd0:  a = 25'sd1152000;
            4'd1:  a = 25'sd680065;
            4'd2:  a = 25'sd359328;
            4'd3:  a = 25'sd182400;
            4'd4:  a = 25'sd91554;
            4'd5:  a = 25'sd45822;
            4'd6:  a = 25'sd22916;
            4'd7:  a = 25'sd11459;
            4'd8:  a = 25'sd5730;
            4'd9:  a = 25'sd2865;
            4'd10: a = 25'sd1432;
            4'd11: a = 25'sd716;
            4'd12: a = 25'sd358;
            4'd13: a = 25'sd179;
            4'd14: a = 25'sd90;
            default: a = 25'sd45;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/ccba_ifs.sv @@
// Valid/ready channel interfaces for the bearing averager.
// Depends on ccba_pkg for field widths.
interface ccba_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [ccba_pkg::BRG_W-1:0]    bearing_in;
    modport source (output valid, kind, bearing_in, input ready);
    modport sink   (input valid, kind, bearing_in, output ready);
endinterface

interface ccba_out_if;
    logic                          valid;
    logic                          ready;
    logic [ccba_pkg::BRG_W-1:0]    bearing_100ms;
    logic [ccba_pkg::BRG_W-1:0]    bearing_1s;
    logic [ccba_pkg::BRG_W-1:0]    bearing_3s;
    logic [ccba_pkg::BRG_W-1:0]    bearing_30s;
    logic [ccba_pkg::BRG_W-1:0]    bearing_10m;
    modport source (output valid, bearing_100ms, bearing_1s, bearing_3s, bearing_30s,
                    bearing_10m, input ready);
    modport sink   (input valid, bearing_100ms, bearing_1s, bearing_3s, bearing_30s,
                    bearing_10m, output ready);
endinterface

@@ rtl/cascaded_circular_bearing_average.sv @@
// Cascaded circular-mean bearing averager: 100 ms, 1 s, 3 s, 30 s and 10 min windows.
// Depends on ccba_pkg, ccba_ifs, ccba_cordic, ccba_div and ccba_ring.
//
// Usage:
//   i_item carries one item per 20 ms tick: kind (tick or preset) and a bearing in
//   hundredths of a degree. o_result carries the five held window bearings, one result
//   per item. One item is in work at a time; i_item.ready is high only when idle.
// Sequence: a cos/sin CORDIC pass, then the 100 ms push (ring read, update and two
//   20-step serial divisions) and the schedule step; the 100 ms bearing is then
//   recomputed by a vectoring pass, or a slower window is pushed the same way and its
//   bearing recomputed, or neither is due. The divider is bit-serial and the CORDIC
//   does one iteration per cycle. A preset takes a CORDIC pass plus a sweep of the
//   sums of the five windows.
// Overlap: a new item is accepted only after the previous result has been transferred.
// Reset: all windows hold the unit vector (1,0), held bearings and the tick counter are
//   zero. Ring entries are tracked by valid bits, so no clearing pass is needed.
// Stall: the result is held on o_result until it is taken; no new item is accepted
//   meanwhile.
module cascaded_circular_bearing_average #(
    parameter int LEN_FAST      = ccba_pkg::LEN_FAST_DEF,
    parameter int LEN_SECOND    = ccba_pkg::LEN_SECOND_DEF,
    parameter int LEN_THREE_SEC = ccba_pkg::LEN_THREE_SEC_DEF,
    parameter int LEN_HALF_MIN  = ccba_pkg::LEN_HALF_MIN_DEF,
    parameter int LEN_TEN_MIN   = ccba_pkg::LEN_TEN_MIN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ccba_in_if.sink       i_item,
    ccba_out_if.source    o_result
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SC   = 4'd1;
    localparam logic [3:0] S_FILL = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_UPD  = 4'd4;
    localparam logic [3:0] S_DVX  = 4'd5;
    localparam logic [3:0] S_DVY  = 4'd6;
    localparam logic [3:0] S_SEL  = 4'd7;
    localparam logic [3:0] S_VST  = 4'd8;
    localparam logic [3:0] S_VEC  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    localparam logic [ccba_pkg::WIN_W-1:0] W_FAST   = 3'd0;
    localparam logic [ccba_pkg::WIN_W-1:0] W_SECOND = 3'd1;
    localparam logic [ccba_pkg::WIN_W-1:0] W_THREE  = 3'd2;
    localparam logic [ccba_pkg::WIN_W-1:0] W_HALF   = 3'd3;
    localparam logic [ccba_pkg::WIN_W-1:0] W_TEN    = 3'd4;

    logic [3:0]                           r_state;
    logic                                 r_kind;
    logic [ccba_pkg::WIN_W-1:0]           r_win;
    logic signed [ccba_pkg::Q_W-1:0]      r_vc, r_vs;
    logic signed [ccba_pkg::SUM_W-1:0]    r_sum_c [ccba_pkg::NWIN];
    logic signed [ccba_pkg::SUM_W-1:0]    r_sum_s [ccba_pkg::NWIN];
    logic [ccba_pkg::POS_W-1:0]           r_pos   [ccba_pkg::NWIN];
    logic signed [ccba_pkg::Q_W-1:0]      r_mean_c [ccba_pkg::NWIN];
    logic signed [ccba_pkg::Q_W-1:0]      r_mean_s [ccba_pkg::NWIN];
    logic [ccba_pkg::BRG_W-1:0]           r_held  [ccba_pkg::NWIN];
    logic [ccba_pkg::TICK_W-1:0]          r_tick;
    logic [2:0]                           r_t5;
    logic [5:0]                           r_t50;

    ccba_pkg::t_ring_req                  ring_req;
    ccba_pkg::t_cordic_req                cor_req;
    ccba_pkg::t_cordic_rsp                cor_rsp;
    logic signed [ccba_pkg::Q_W-1:0]      ring_c, ring_s;
    logic                                 div_start, div_done;
    logic signed [ccba_pkg::SUM_W-1:0]    div_sum;
    logic signed [ccba_pkg::Q_W-1:0]      div_q;

    logic [ccba_pkg::LEN_W-1:0]           len_cur;
    logic [ccba_pkg::POS_W-1:0]           pos_eff, pos_nxt;
    logic [ccba_pkg::LEN_W-1:0]           pos_inc;
    logic signed [ccba_pkg::SUM_W-1:0]    sum_c_new, sum_s_new;
    logic                                 in_xfer;
    logic [2:0]                           t5_n;
    logic [5:0]                           t50_n;
    logic [ccba_pkg::TICK_W-1:0]          tick_n;

    always_comb begin
        unique case (r_win)
            W_FAST:   len_cur = ccba_pkg::clamp_len(LEN_FAST);
            W_SECOND: len_cur = ccba_pkg::clamp_len(LEN_SECOND);
            W_THREE:  len_cur = ccba_pkg::clamp_len(LEN_THREE_SEC);
            W_HALF:   len_cur = ccba_pkg::clamp_len(LEN_HALF_MIN);
            default:  len_cur = ccba_pkg::clamp_len(LEN_TEN_MIN);
        endcase
    end

    assign in_xfer = i_item.valid & i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);

    assign pos_eff = ({1'b0, r_pos[r_win]} >= len_cur) ? '0 : r_pos[r_win];
    assign pos_inc = {1'b0, pos_eff} + 1'b1;
    assign pos_nxt = (pos_inc >= len_cur) ? '0 : pos_inc[ccba_pkg::POS_W-1:0];

    assign sum_c_new = r_sum_c[r_win] + ccba_pkg::SUM_W'(r_vc) - ccba_pkg::SUM_W'(ring_c);
    assign sum_s_new = r_sum_s[r_win] + ccba_pkg::SUM_W'(r_vs) - ccba_pkg::SUM_W'(ring_s);

    assign t5_n   = (r_t5 == ccba_pkg::PHASE_LAST) ? '0 : r_t5 + 1'b1;
    assign t50_n  = (r_t50 == ccba_pkg::SLOW_LAST) ? '0 : r_t50 + 1'b1;
    assign tick_n = r_tick + 1'b1;

    always_comb begin
        ring_req.rd  = (r_state == S_RD);
        ring_req.wr  = (r_state == S_UPD);
        ring_req.clr = (r_state == S_SC) && cor_rsp.done && (r_kind == ccba_pkg::KIND_PRESET);
        ring_req.win = r_win;
        ring_req.pos = pos_eff;
        ring_req.vc  = ring_req.clr ? cor_rsp.c : r_vc;
        ring_req.vs  = ring_req.clr ? cor_rsp.s : r_vs;

        cor_req.start   = in_xfer || (r_state == S_VST);
        cor_req.vec     = (r_state == S_VST);
        cor_req.bearing = i_item.bearing_in;
        cor_req.vx      = r_mean_c[r_win];
        cor_req.vy      = r_mean_s[r_win];

        div_start = (r_state == S_UPD) || ((r_state == S_DVX) && div_done);
        div_sum   = (r_state == S_UPD) ? sum_c_new : r_sum_s[r_win];
    end

    ccba_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .o_rsp   (cor_rsp)
    );

    ccba_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (div_sum),
        .i_len   (len_cur),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    ccba_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ring_req),
        .o_rc    (ring_c),
        .o_rs    (ring_s)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= ccba_pkg::KIND_TICK;
            r_win   <= W_FAST;
            r_tick  <= '0;
            r_t5    <= '0;
            r_t50   <= '0;
            r_vc    <= ccba_pkg::QONE;
            r_vs    <= '0;
            for (int w = 0; w < ccba_pkg::NWIN; w++) begin
                r_sum_c[w]  <= ccba_pkg::SUM_W'(ccba_pkg::QONE) * ccba_pkg::SUM_W'(
                    ccba_pkg::clamp_len(w == 0 ? LEN_FAST : w == 1 ? LEN_SECOND :
                                        w == 2 ? LEN_THREE_SEC : w == 3 ? LEN_HALF_MIN :
                                        LEN_TEN_MIN));
                r_sum_s[w]  <= '0;
                r_pos[w]    <= '0;
                r_mean_c[w] <= ccba_pkg::QONE;
                r_mean_s[w] <= '0;
                r_held[w]   <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_kind  <= i_item.kind;
                        r_state <= S_SC;
                    end
                end
                S_SC: begin
                    if (cor_rsp.done) begin
                        r_vc  <= cor_rsp.c;
                        r_vs  <= cor_rsp.s;
                        r_win <= W_FAST;
                        r_state <= (r_kind == ccba_pkg::KIND_PRESET) ? S_FILL : S_RD;
                    end
                end
                S_FILL: begin
                    // one window per cycle: sums, means and position from the preset vector
                    r_sum_c[r_win]  <= ccba_pkg::SUM_W'($signed({1'b0, len_cur}))
                                       * ccba_pkg::SUM_W'(r_vc);
                    r_sum_s[r_win]  <= ccba_pkg::SUM_W'($signed({1'b0, len_cur}))
                                       * ccba_pkg::SUM_W'(r_vs);
                    r_mean_c[r_win] <= r_vc;
                    r_mean_s[r_win] <= r_vs;
                    r_pos[r_win]    <= '0;
                    if (r_win == W_TEN) begin
                        r_tick  <= '0;
                        r_t5    <= '0;
                        r_t50   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_win <= r_win + 1'b1;
                    end
                end
                S_RD: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_sum_c[r_win] <= sum_c_new;
                    r_sum_s[r_win] <= sum_s_new;
                    r_pos[r_win]   <= pos_nxt;
                    r_state        <= S_DVX;
                end
                S_DVX: begin
                    if (div_done) begin
                        r_mean_c[r_win] <= div_q;
                        r_state         <= S_DVY;
                    end
                end
                S_DVY: begin
                    if (div_done) begin
                        r_mean_s[r_win] <= div_q;
                        r_state <= (r_win == W_FAST) ? S_SEL : S_VST;
                    end
                end
                S_SEL: begin
                    // staggered schedule, first matching slot wins
                    r_tick <= tick_n;
                    r_t5   <= t5_n;
                    r_t50  <= t50_n;
                    if (t5_n == 3'd0) begin
                        r_win   <= W_FAST;
                        r_state <= S_VST;
                    end else if (t5_n == 3'd1) begin
                        r_win   <= W_SECOND;
                        r_vc    <= r_mean_c[W_FAST];
                        r_vs    <= r_mean_s[W_FAST];
                        r_state <= S_RD;
                    end else if (t5_n == 3'd2) begin
                        r_win   <= W_THREE;
                        r_vc    <= r_mean_c[W_FAST];
                        r_vs    <= r_mean_s[W_FAST];
                        r_state <= S_RD;
                    end else if (t50_n == 6'd3) begin
                        r_win   <= W_HALF;
                        r_vc    <= r_mean_c[W_THREE];
                        r_vs    <= r_mean_s[W_THREE];
                        r_state <= S_RD;
                    end else if (tick_n == ccba_pkg::TEN_MIN_TICK) begin
                        r_win   <= W_TEN;
                        r_vc    <= r_mean_c[W_HALF];
                        r_vs    <= r_mean_s[W_HALF];
                        r_tick  <= ccba_pkg::TEN_MIN_RESTART;
                        r_t5    <= 3'(ccba_pkg::TEN_MIN_RESTART);
                        r_t50   <= 6'(ccba_pkg::TEN_MIN_RESTART);
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_VST: begin
                    r_state <= S_VEC;
                end
                S_VEC: begin
                    if (cor_rsp.done) begin
                        r_held[r_win] <= cor_rsp.bearing;
                        r_state       <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_result.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid         = (r_state == S_OUT);
    assign o_result.bearing_100ms = r_held[W_FAST];
    assign o_result.bearing_1s    = r_held[W_SECOND];
    assign o_result.bearing_3s    = r_held[W_THREE];
    assign o_result.bearing_30s   = r_held[W_HALF];
    assign o_result.bearing_10m   = r_held[W_TEN];

    a_tick_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick <= ccba_pkg::TEN_MIN_TICK)
        else $error("tick counter past the 10 min restart point");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_t5 <= ccba_pkg::PHASE_LAST) && (r_t50 <= ccba_pkg::SLOW_LAST))
        else $error("phase counters out of range");

    a_start_cordic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_SC))
        else $error("accepted item did not start the sin/cos pass");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_result.valid) |-> $past(o_result.ready))
        else $error("result dropped without a transfer");
endmodule

@@ rtl/ccba_cordic.sv @@
// Iterative CORDIC, one micro-rotation per cycle: bearing to cos/sin, or vector to bearing.
// Depends on ccba_pkg.
module ccba_cordic (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ccba_pkg::t_cordic_req i_req,
    output ccba_pkg::t_cordic_rsp o_rsp
);
    logic                                r_busy, r_fin, r_vec, r_flip, r_zero;
    logic [ccba_pkg::IT_W-1:0]           r_it;
    logic signed [ccba_pkg::CXY_W-1:0]   r_x, r_y;
    logic signed [ccba_pkg::CZ_W-1:0]    r_z;

    logic [16:0]                         b_red;
    logic signed [16:0]                  z_fold;
    logic                                flip;
    logic signed [ccba_pkg::CXY_W-1:0]   vx, vy, dx, dy, xr, yr;
    logic signed [ccba_pkg::CZ_W-1:0]    zr;
    logic signed [16:0]                  brg;
    logic                                pos_dir;
    logic signed [ccba_pkg::Q_W-1:0]     c_sat, s_sat;

    always_comb begin
        b_red = {1'b0, i_req.bearing};
        if (b_red >= ccba_pkg::FULL_TURN) begin
            b_red = b_red - ccba_pkg::FULL_TURN;
        end
        flip = 1'b0;
        if (b_red <= ccba_pkg::QUARTER) begin
            z_fold = signed'(b_red);
        end else if (b_red >= ccba_pkg::THREE_QTR) begin
            z_fold = signed'(b_red - ccba_pkg::FULL_TURN);
        end else begin
            z_fold = signed'(b_red - ccba_pkg::HALF_TURN);
            flip   = 1'b1;
        end
        vx = ccba_pkg::CXY_W'(i_req.vx) <<< 2;
        vy = ccba_pkg::CXY_W'(i_req.vy) <<< 2;
    end

    assign dx = r_y >>> r_it;
    assign dy = r_x >>> r_it;
    assign pos_dir = r_vec ? (r_y < 0) : (r_z >= 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_it   <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_it   <= '0;
            end else if (r_busy) begin
                r_it <= r_it + 1'b1;
                if (r_it == ccba_pkg::CORDIC_LAST) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_vec  <= i_req.vec;
            r_flip <= flip & ~i_req.vec;
            r_zero <= (i_req.vx == '0) && (i_req.vy == '0);
            if (i_req.vec) begin
                if (vx < 0) begin
                    r_x <= -vx;
                    r_y <= -vy;
                    r_z <= ccba_pkg::Z_HALF_TURN;
                end else begin
                    r_x <= vx;
                    r_y <= vy;
                    r_z <= '0;
                end
            end else begin
                r_x <= ccba_pkg::CORDIC_X0;
                r_y <= '0;
                r_z <= ccba_pkg::CZ_W'(z_fold) <<< ccba_pkg::ANG_SHIFT;
            end
        end else if (r_busy) begin
            if (pos_dir) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - ccba_pkg::atan_step(r_it);
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + ccba_pkg::atan_step(r_it);
            end
        end
    end

    // output rounding: Q4.17 -> Q1.15, and 1/25600 deg -> 1/100 deg
    always_comb begin
        xr    = (r_x + 21'sd2) >>> 2;
        yr    = (r_y + 21'sd2) >>> 2;
        c_sat = ccba_pkg::sat_q15(xr);
        s_sat = ccba_pkg::sat_q15(yr);
        zr    = (r_z + 25'sd128) >>> ccba_pkg::ANG_SHIFT;
        brg   = zr[16:0];
        if (brg < 0) begin
            brg = brg + signed'(ccba_pkg::FULL_TURN);
        end
        o_rsp.done    = r_fin;
        o_rsp.c       = r_flip ? -c_sat : c_sat;
        o_rsp.s       = r_flip ? -s_sat : s_sat;
        o_rsp.bearing = r_zero ? '0 : brg[ccba_pkg::BRG_W-1:0];
    end
endmodule

@@ rtl/ccba_div.sv @@
// Bit-serial restoring divider: rounded mean of a window sum by its length.
// Depends on ccba_pkg.
module ccba_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [ccba_pkg::SUM_W-1:0]  i_sum,
    input  logic [ccba_pkg::LEN_W-1:0]         i_len,
    output logic                               o_done,
    output logic signed [ccba_pkg::Q_W-1:0]    o_q
);
    logic                              r_busy, r_fin, r_neg;
    logic [ccba_pkg::DCNT_W-1:0]       r_cnt;
    logic [ccba_pkg::DVD_W-1:0]        r_dvd;
    logic [ccba_pkg::LEN_W-1:0]        r_rem;
    logic [ccba_pkg::LEN_W-1:0]        r_len;

    logic [ccba_pkg::SUM_W-1:0]        mag;
    logic [ccba_pkg::LEN_W:0]          trial;
    logic                              qbit;
    logic signed [ccba_pkg::Q_W-1:0]   q_sat;

    assign mag   = (i_sum < 0) ? ccba_pkg::SUM_W'(-i_sum) : ccba_pkg::SUM_W'(i_sum);
    assign trial = {r_rem, r_dvd[ccba_pkg::DVD_W-1]};
    assign qbit  = trial >= {1'b0, r_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ccba_pkg::DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift into the low end as dividend bits leave the top
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= ccba_pkg::DVD_W'(mag + ccba_pkg::SUM_W'(i_len >> 1));
            r_neg <= i_sum < 0;
            r_rem <= '0;
            r_len <= i_len;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[ccba_pkg::DVD_W-2:0], qbit};
            r_rem <= qbit ? ccba_pkg::LEN_W'(trial - {1'b0, r_len})
                          : ccba_pkg::LEN_W'(trial);
        end
    end

    assign q_sat  = ccba_pkg::sat_q15(signed'({1'b0, r_dvd}));
    assign o_q    = r_neg ? -q_sat : q_sat;
    assign o_done = r_fin;
endmodule

@@ rtl/ccba_ring.sv @@
// Ring store of all five windows, one read and one write port, registered read.
// Depends on ccba_pkg. Entries never written since reset or preset read as the fill vector.
module ccba_ring (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ccba_pkg::t_ring_req              i_req,
    output logic signed [ccba_pkg::Q_W-1:0]  o_rc,
    output logic signed [ccba_pkg::Q_W-1:0]  o_rs
);
    localparam int DEPTH  = ccba_pkg::NWIN * ccba_pkg::MAXLEN;
    localparam int ADDR_W = ccba_pkg::WIN_W + ccba_pkg::POS_W;

    logic [2*ccba_pkg::Q_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]           r_valid;
    logic [2*ccba_pkg::Q_W-1:0] r_fill;
    logic [2*ccba_pkg::Q_W-1:0] r_rd_data;
    logic                       r_rd_valid;
    logic [ADDR_W-1:0]          addr;

    assign addr = {i_req.win, i_req.pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fill  <= {ccba_pkg::QONE, {ccba_pkg::Q_W{1'b0}}};
        end else if (i_req.clr) begin
            r_valid <= '0;
            r_fill  <= {i_req.vc, i_req.vs};
        end else if (i_req.wr) begin
            r_valid[addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[addr] <= {i_req.vc, i_req.vs};
        end
        if (i_req.rd) begin
            r_rd_data  <= r_mem[addr];
            r_rd_valid <= r_valid[addr];
        end
    end

    assign o_rc = r_rd_valid ? r_rd_data[2*ccba_pkg::Q_W-1:ccba_pkg::Q_W]
                             : r_fill[2*ccba_pkg::Q_W-1:ccba_pkg::Q_W];
    assign o_rs = r_rd_valid ? r_rd_data[ccba_pkg::Q_W-1:0] : r_fill[ccba_pkg::Q_W-1:0];
endmodule
